// ===== src/msfp_pkg.sv =====
// ---------------------------------------------------------------------------
// msfp_pkg - motor status frame parser shared definitions
// Frame layout, record commands, register reset value and the packed result.
// ---------------------------------------------------------------------------
package msfp_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned OFFSET_W    = $clog2(FRAME_BYTES);
  localparam int unsigned MOTOR_COUNT = 2;
  localparam int unsigned SIDE_W      = 1;

  // Record indexes within a frame (byte offset / 4)
  localparam logic [2:0] REC_FAULT    = 3'd0;
  localparam logic [2:0] REC_CURRENT  = 3'd2;
  localparam logic [2:0] REC_SPEED    = 3'd3;
  localparam logic [2:0] REC_POS_HIGH = 3'd6;
  localparam logic [2:0] REC_POS_LOW  = 3'd7;

  // Record commands
  localparam logic [7:0] CMD_FAULT    = 8'h80;
  localparam logic [7:0] CMD_CURRENT  = 8'he2;
  localparam logic [7:0] CMD_SPEED    = 8'he4;
  localparam logic [7:0] CMD_POS_HIGH = 8'he8;
  localparam logic [7:0] CMD_POS_LOW  = 8'he9;

  // Checksum byte sits at the last place of each 4-byte record
  localparam logic [1:0] CSUM_SLOT = 2'd3;

  // Overcurrent threshold after reset, 10 mA units
  localparam logic [15:0] LIMIT_RESET = 16'd1500;

  // Update flag bit positions
  localparam int unsigned FLAG_POS     = 0;
  localparam int unsigned FLAG_SPEED   = 1;
  localparam int unsigned FLAG_CURRENT = 2;
  localparam int unsigned FLAG_FAULT   = 3;

  // Result word, position in the lowest bits
  typedef struct packed {
    logic [1:0]        pad;
    logic              fault_updated;
    logic              current_updated;
    logic              speed_updated;
    logic              position_updated;
    logic [1:0]        overcurrent_mask;
    logic [7:0]        fault_status;
    logic [15:0]       current;
    logic [15:0]       speed;
    logic signed [31:0] position;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== src/motor_status_frame_parser.sv =====
// Path: the request carrying the last frame byte passes the input register, then
// the result register, before its result reaches the master side.
// Throughput: one byte per cycle, set by the record update between the input
// register and the per-side state; a stalled result holds back only a
// frame-ending byte.
// Reset (rst, synchronous): clears all per-side state, overcurrent bits and
// valids, and loads the current limit with 1500.
// ---------------------------------------------------------------------------
// motor_status_frame_parser - per-side 32-byte status frame decoder
// Checks each 4-byte record, updates stored values and reports per frame.
// ---------------------------------------------------------------------------
module motor_status_frame_parser (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: current limit
  input  logic                         cfg_we,
  input  logic [15:0]                  cfg_wdata,
  // byte input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // data_byte
  input  logic [1:0]                   s_axis_tuser,  // side, frame_start
  // frame result
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [msfp_pkg::RESULT_W-1:0] m_axis_tdata, // position, speed, current,
                                                      // fault_status,
                                                      // overcurrent_mask,
                                                      // position_updated,
                                                      // speed_updated,
                                                      // current_updated,
                                                      // fault_updated, zero pad
  output logic [0:0]                   m_axis_tuser   // motor_side
);
  import msfp_pkg::*;

  // Configuration
  logic [15:0] current_limit;

  // Input register
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic [SIDE_W-1:0] s1_side;
  logic              s1_start;

  // Per-side state
  logic [OFFSET_W-1:0] byte_offset       [MOTOR_COUNT];
  logic [23:0]         record_bytes      [MOTOR_COUNT];
  logic [16:0]         pending_high_half [MOTOR_COUNT];
  logic [31:0]         stored_position   [MOTOR_COUNT];
  logic [15:0]         stored_speed      [MOTOR_COUNT];
  logic [15:0]         stored_current    [MOTOR_COUNT];
  logic [7:0]          stored_fault      [MOTOR_COUNT];
  logic [3:0]          frame_update_flags[MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] overcurrent_bits;

  // Result register
  result_t           result;
  logic [SIDE_W-1:0] result_side;

  // Record decode
  logic                side_ok;
  logic [OFFSET_W-1:0] pos;
  logic                frame_first;
  logic                frame_last;
  logic [2:0]          rec_index;
  logic [7:0]          rec_cmd, rec_hi, rec_lo, csum;
  logic [15:0]         rec_val;
  logic                rec_done;
  logic                rec_ok;

  // Next values for the selected side
  logic [OFFSET_W-1:0]    byte_offset_next;
  logic [23:0]            record_bytes_next;
  logic [16:0]            pending_next;
  logic [31:0]            position_next;
  logic [15:0]            speed_next;
  logic [15:0]            current_next;
  logic [7:0]             fault_next;
  logic [3:0]             flags_next;
  logic [MOTOR_COUNT-1:0] overcurrent_next;

  logic s_fire, s1_go, out_load;

  // Locate the byte within its side's frame
  assign side_ok     = (32'(s1_side) < MOTOR_COUNT);
  assign pos         = s1_start ? '0 : byte_offset[s1_side];
  assign frame_first = (pos == '0);
  assign frame_last  = (pos == OFFSET_W'(FRAME_BYTES - 1));
  assign rec_index   = pos[OFFSET_W-1:2];
  assign rec_done    = (pos[1:0] == CSUM_SLOT);
  assign rec_cmd     = record_bytes[s1_side][23:16];
  assign rec_hi      = record_bytes[s1_side][15:8];
  assign rec_lo      = record_bytes[s1_side][7:0];
  assign rec_val     = {rec_hi, rec_lo};
  assign csum        = rec_cmd + rec_hi + rec_lo;
  assign rec_ok      = rec_done && (csum == s1_byte);

  // Update the selected side's values for this byte
  always_comb begin
    record_bytes_next = record_bytes[s1_side];
    pending_next      = frame_first ? '0 : pending_high_half[s1_side];
    flags_next        = frame_first ? '0 : frame_update_flags[s1_side];
    position_next     = stored_position[s1_side];
    speed_next        = stored_speed[s1_side];
    current_next      = stored_current[s1_side];
    fault_next        = stored_fault[s1_side];
    overcurrent_next  = overcurrent_bits;
    byte_offset_next  = frame_last ? '0 : pos + OFFSET_W'(1);

    if (!rec_done) begin
      record_bytes_next = {record_bytes[s1_side][15:0], s1_byte};
    end else if (rec_ok) begin
      case (rec_index)
        REC_FAULT: begin
          if (rec_cmd == CMD_FAULT) begin
            fault_next             = rec_lo;
            flags_next[FLAG_FAULT] = 1'b1;
          end
        end
        REC_CURRENT: begin
          if (rec_cmd == CMD_CURRENT) begin
            current_next                = rec_val;
            flags_next[FLAG_CURRENT]    = 1'b1;
            overcurrent_next[s1_side]   = (rec_val > current_limit);
          end
        end
        REC_SPEED: begin
          if (rec_cmd == CMD_SPEED) begin
            speed_next             = rec_val;
            flags_next[FLAG_SPEED] = 1'b1;
          end
        end
        REC_POS_HIGH: begin
          if (rec_cmd == CMD_POS_HIGH) begin
            pending_next = {1'b1, rec_val};
          end
        end
        REC_POS_LOW: begin
          if (rec_cmd == CMD_POS_LOW && pending_next[16]) begin
            position_next        = {pending_next[15:0], rec_val};
            flags_next[FLAG_POS] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: a frame-ending byte waits for room in the result register
  assign s1_go         = s1_valid && (!(side_ok && frame_last) || !m_axis_tvalid ||
                                      m_axis_tready);
  assign out_load      = s1_go && side_ok && frame_last;
  assign s_axis_tready = !s1_valid || s1_go;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Hold the current limit
  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      current_limit <= cfg_wdata;
    end
  end

  // Capture the request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_byte  <= s_axis_tdata;
      s1_side  <= s_axis_tuser[0];
      s1_start <= s_axis_tuser[1];
    end
  end

  // Write back the side's state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        byte_offset[i]        <= '0;
        record_bytes[i]       <= '0;
        pending_high_half[i]  <= '0;
        stored_position[i]    <= '0;
        stored_speed[i]       <= '0;
        stored_current[i]     <= '0;
        stored_fault[i]       <= '0;
        frame_update_flags[i] <= '0;
      end
      overcurrent_bits <= '0;
    end else if (s1_go && side_ok) begin
      byte_offset[s1_side]        <= byte_offset_next;
      record_bytes[s1_side]       <= record_bytes_next;
      pending_high_half[s1_side]  <= pending_next;
      stored_position[s1_side]    <= position_next;
      stored_speed[s1_side]       <= speed_next;
      stored_current[s1_side]     <= current_next;
      stored_fault[s1_side]       <= fault_next;
      frame_update_flags[s1_side] <= flags_next;
      overcurrent_bits            <= overcurrent_next;
    end
  end

  // Load the frame result; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_side             <= s1_side;
      result.pad              <= '0;
      result.fault_updated    <= flags_next[FLAG_FAULT];
      result.current_updated  <= flags_next[FLAG_CURRENT];
      result.speed_updated    <= flags_next[FLAG_SPEED];
      result.position_updated <= flags_next[FLAG_POS];
      result.overcurrent_mask <= overcurrent_next[1:0];
      result.fault_status     <= fault_next;
      result.current          <= current_next;
      result.speed            <= speed_next;
      result.position         <= position_next;
    end
  end

  assign m_axis_tdata = result;
  assign m_axis_tuser = result_side;

  // A frame result restarts that side's byte count
  a_offset_wraps: assert property (@(posedge clk) disable iff (rst)
    out_load |=> byte_offset[result_side] == '0)
    else $error("byte offset not cleared after frame result");

  // A position update needs a checked high half in the same frame
  a_pos_needs_high: assert property (@(posedge clk) disable iff (rst)
    out_load && flags_next[FLAG_POS] |-> pending_next[16])
    else $error("position updated without valid high half");

  // Input is held off only while the input register is occupied and a result waits untaken
  a_ready_reason: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

endmodule

// ===== dv/msfp_frame_checker.sv =====
// ---------------------------------------------------------------------------
// msfp_frame_checker - frame report predictor and scoreboard
// Watches the byte, result and register ports of the status frame parser,
// decodes every accepted byte into per-side motor state and compares each
// frame report with the oldest one predicted.
// ---------------------------------------------------------------------------
module msfp_frame_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // data_byte
  input  logic [1:0]                    s_axis_tuser,   // side, frame_start
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [msfp_pkg::RESULT_W-1:0] m_axis_tdata,   // position, speed, current,
                                                        // fault_status,
                                                        // overcurrent_mask,
                                                        // update flags, pad
  input  logic [0:0]                    m_axis_tuser,   // motor_side
  output int                            fail_count,
  output int                            reports_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import msfp_pkg::*;

  typedef struct {
    logic    side;
    result_t word;
  } frame_report_t;

  frame_report_t report_q[$];

  // Modelled parser state, one slot per motor side
  logic [15:0]          limit_model;
  logic [OFFSET_W-1:0]  offset_m    [MOTOR_COUNT];
  logic [23:0]          rec_bytes   [MOTOR_COUNT];
  logic [16:0]          high_half   [MOTOR_COUNT];
  logic signed [31:0]   position_m  [MOTOR_COUNT];
  logic [15:0]          speed_m     [MOTOR_COUNT];
  logic [15:0]          current_m   [MOTOR_COUNT];
  logic [7:0]           fault_m     [MOTOR_COUNT];
  logic [3:0]           flags_m     [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] overcurrent_m;

  // Apply one record once its checksum byte is in
  task automatic close_record(input int s, input logic [2:0] idx, input logic [7:0] csum);
    logic [7:0]  cmd;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  sum;
    logic [15:0] val;
    cmd = rec_bytes[s][23:16];
    hi  = rec_bytes[s][15:8];
    lo  = rec_bytes[s][7:0];
    val = {hi, lo};
    sum = cmd + hi + lo;
    if (sum != csum) return;
    if (idx == REC_FAULT && cmd == CMD_FAULT) begin
      fault_m[s] = lo;
      flags_m[s][FLAG_FAULT] = 1'b1;
    end else if (idx == REC_CURRENT && cmd == CMD_CURRENT) begin
      current_m[s] = val;
      flags_m[s][FLAG_CURRENT] = 1'b1;
      overcurrent_m[s] = (val > limit_model);
    end else if (idx == REC_SPEED && cmd == CMD_SPEED) begin
      speed_m[s] = val;
      flags_m[s][FLAG_SPEED] = 1'b1;
    end else if (idx == REC_POS_HIGH && cmd == CMD_POS_HIGH) begin
      high_half[s] = {1'b1, val};
    end else if (idx == REC_POS_LOW && cmd == CMD_POS_LOW) begin
      // low half counts only after a good high half in this frame
      if (high_half[s][16]) begin
        position_m[s] = {high_half[s][15:0], val};
        flags_m[s][FLAG_POS] = 1'b1;
      end
    end
  endtask

  // Advance one side by one status byte; queue a report at the frame end
  task automatic decode_status_byte(input logic [7:0] b, input logic side,
                                    input logic start);
    int                  si;
    logic [OFFSET_W-1:0] pos;
    frame_report_t       rep;
    si = int'(side);
    if (si >= MOTOR_COUNT) return;
    if (start) offset_m[si] = '0;
    pos = offset_m[si];
    if (pos == 0) begin
      flags_m[si]   = '0;
      high_half[si] = '0;
    end
    if (pos[1:0] != CSUM_SLOT) rec_bytes[si] = {rec_bytes[si][15:0], b};
    else close_record(si, pos[4:2], b);
    if (pos == FRAME_BYTES - 1) begin
      rep.side                  = side;
      rep.word                  = '0;
      rep.word.position         = position_m[si];
      rep.word.speed            = speed_m[si];
      rep.word.current          = current_m[si];
      rep.word.fault_status     = fault_m[si];
      rep.word.overcurrent_mask = overcurrent_m;
      rep.word.position_updated = flags_m[si][FLAG_POS];
      rep.word.speed_updated    = flags_m[si][FLAG_SPEED];
      rep.word.current_updated  = flags_m[si][FLAG_CURRENT];
      rep.word.fault_updated    = flags_m[si][FLAG_FAULT];
      report_q.push_back(rep);
      offset_m[si] = '0;
    end else begin
      offset_m[si] = pos + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare a frame report with the oldest prediction
  task automatic check_report(input logic side, input result_t got);
    frame_report_t want;
    if (report_q.size() == 0) begin
      fail_count++;
      $display("%0t: report with no frame pending, expected none, got side %0d data %0h",
               $time, side, got);
      return;
    end
    want = report_q.pop_front();
    check_field("motor_side", 64'(want.side), 64'(side));
    check_field("position", 64'($unsigned(want.word.position)),
                64'($unsigned(got.position)));
    check_field("speed", 64'(want.word.speed), 64'(got.speed));
    check_field("current", 64'(want.word.current), 64'(got.current));
    check_field("fault_status", 64'(want.word.fault_status), 64'(got.fault_status));
    check_field("overcurrent_mask", 64'(want.word.overcurrent_mask),
                64'(got.overcurrent_mask));
    check_field("position_updated", 64'(want.word.position_updated),
                64'(got.position_updated));
    check_field("speed_updated", 64'(want.word.speed_updated), 64'(got.speed_updated));
    check_field("current_updated", 64'(want.word.current_updated),
                64'(got.current_updated));
    check_field("fault_updated", 64'(want.word.fault_updated), 64'(got.fault_updated));
  endtask

  // Sample all channels at the rising edge, results before requests
  always @(posedge clk) begin
    if (rst) begin
      fail_count    = 0;
      limit_model   = LIMIT_RESET;
      overcurrent_m = '0;
      report_q.delete();
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        offset_m[i]   = '0;
        rec_bytes[i]  = '0;
        high_half[i]  = '0;
        position_m[i] = '0;
        speed_m[i]    = '0;
        current_m[i]  = '0;
        fault_m[i]    = '0;
        flags_m[i]    = '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tuser[0], m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        decode_status_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
      if (cfg_we) limit_model = cfg_wdata;
    end
    reports_due = report_q.size();
  end

endmodule

// ===== dv/tb_motor_status_frame_parser.sv =====
// ---------------------------------------------------------------------------
// tb_motor_status_frame_parser - status frame parser testbench
// Feeds directed and random status frames for both motor sides under several
// current limits, with random idling on both ports and one long result
// hold-off; the frame checker predicts and compares every report.
// ---------------------------------------------------------------------------
module tb_motor_status_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import msfp_pkg::*;

  localparam int RUN_LIMIT   = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 265;
  localparam int SETTLE      = 8;
  localparam int CALM_PHASE  = 2;
  localparam int HOLD_PHASE  = 3;

  typedef struct packed {
    logic       start;
    logic       side;
    logic [7:0] data;
  } status_byte_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // data_byte
  logic [1:0]          s_axis_tuser;   // side, frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [RESULT_W-1:0] m_axis_tdata;   // position, speed, current, fault_status,
                                       // overcurrent_mask, update flags, pad
  logic [0:0]          m_axis_tuser;   // motor_side
  int                  fail_count;
  int                  reports_due;
  int                  phase_no = 0;
  int                  cycle_count = 0;
  logic [15:0]         cur_limit = LIMIT_RESET;
  bit                  side_aligned [2];

  status_byte_t lane0[$];
  status_byte_t lane1[$];
  status_byte_t tx_q[$];

  motor_status_frame_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  msfp_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .reports_due   (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, none in the calm phase, one long hold-off
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == HOLD_PHASE && !held) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (phase_no == CALM_PHASE) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_lane(input logic s, input status_byte_t b);
    if (s) lane1.push_back(b);
    else lane0.push_back(b);
  endtask

  task automatic trim_lane(input logic s, input int n);
    repeat (n) begin
      if (s) void'(lane1.pop_back());
      else void'(lane0.pop_back());
    end
  endtask

  // Queue one 32-byte frame; a clear bit in good spoils that record
  task automatic put_frame(input logic s, input logic mark, input logic [15:0] fault,
                           input logic [15:0] cur, input logic [15:0] spd,
                           input logic [15:0] pos_hi, input logic [15:0] pos_lo,
                           input logic [7:0] good);
    logic [7:0]  cmd;
    logic [7:0]  csum;
    logic [15:0] val;
    for (int r = 0; r < 8; r++) begin
      case (3'(r))
        REC_FAULT:    begin cmd = CMD_FAULT;    val = fault;  end
        REC_CURRENT:  begin cmd = CMD_CURRENT;  val = cur;    end
        REC_SPEED:    begin cmd = CMD_SPEED;    val = spd;    end
        REC_POS_HIGH: begin cmd = CMD_POS_HIGH; val = pos_hi; end
        REC_POS_LOW:  begin cmd = CMD_POS_LOW;  val = pos_lo; end
        default: begin
          cmd = 8'($urandom_range(0, 255));
          val = pick_word();
        end
      endcase
      csum = cmd + val[15:8] + val[7:0];
      if (!good[r]) begin
        if ($urandom_range(0, 1)) cmd = cmd ^ 8'($urandom_range(1, 255));
        else csum = csum ^ 8'($urandom_range(1, 255));
      end
      push_lane(s, '{start: mark && r == 0, side: s, data: cmd});
      push_lane(s, '{start: 1'b0, side: s, data: val[15:8]});
      push_lane(s, '{start: 1'b0, side: s, data: val[7:0]});
      push_lane(s, '{start: 1'b0, side: s, data: csum});
    end
  endtask

  // Frame with random content, current often close to the limit
  task automatic random_frame(input logic s, input logic mark);
    logic [15:0] cur;
    logic [7:0]  good;
    case ($urandom_range(0, 5))
      0:       cur = cur_limit;
      1:       cur = cur_limit + 16'd1;
      2:       cur = cur_limit - 16'd1;
      default: cur = pick_word();
    endcase
    for (int i = 0; i < 8; i++) good[i] = ($urandom_range(0, 99) < 85);
    put_frame(s, mark, pick_word(), cur, pick_word(), pick_word(), pick_word(), good);
  endtask

  // Mostly whole frames, some cut short, some stray bytes
  task automatic random_traffic(input int budget);
    int   made;
    int   act;
    int   n;
    logic s;
    made = 0;
    while (made < budget) begin
      s   = 1'($urandom_range(0, 1));
      act = $urandom_range(0, 99);
      if (act < 80) begin
        random_frame(s, side_aligned[s] ? ($urandom_range(0, 99) < 70) : 1'b1);
        side_aligned[s] = 1'b1;
        made += FRAME_BYTES;
      end else if (act < 90) begin
        n = $urandom_range(1, FRAME_BYTES - 1);
        random_frame(s, 1'b1);
        trim_lane(s, FRAME_BYTES - n);
        side_aligned[s] = 1'b0;
        made += n;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n)
          push_lane(s, '{start: ($urandom_range(0, 99) < 10), side: s,
                         data: 8'($urandom_range(0, 255))});
        side_aligned[s] = 1'b0;
        made += n;
      end
    end
  endtask

  // Merge the two sides at random, keeping each side's byte order
  task automatic interleave_lanes();
    while (lane0.size() != 0 || lane1.size() != 0) begin
      if (lane1.size() == 0 || (lane0.size() != 0 && $urandom_range(0, 1)))
        tx_q.push_back(lane0.pop_front());
      else
        tx_q.push_back(lane1.pop_front());
    end
  endtask

  // Offer one byte request and hold it until taken
  task automatic send_byte(input status_byte_t b);
    if (phase_no != CALM_PHASE && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tdata  <= b.data;
    s_axis_tuser  <= {b.start, b.side};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_all();
    interleave_lanes();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // Let every predicted report out, then the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
  endtask

  initial begin
    logic [15:0] limits [5];
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    side_aligned[0] = 1'b1;
    side_aligned[1] = 1'b1;
    limits = '{LIMIT_RESET, 16'h0000, 16'hffff, 16'($urandom_range(1, 65534)), 16'h0001};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: all-ones frame, all-zero frame with the most negative position
    put_frame(1'b0, 1'b1, 16'h00ff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    put_frame(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 8'hff);
    // frame reached by wrapping: spoilt fault and high half, good low half,
    // current exactly at the limit
    put_frame(1'b0, 1'b0, 16'h0012, LIMIT_RESET, 16'h1234, 16'h7fff, 16'hffff,
              8'b1011_1110);
    // partial frame dropped by a new start mark, then current above the limit
    put_frame(1'b1, 1'b1, 16'h0055, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 8'hff);
    trim_lane(1'b1, FRAME_BYTES - 10);
    put_frame(1'b1, 1'b1, 16'h00a5, LIMIT_RESET + 16'd1, 16'h0fff, 16'h0001,
              16'h0002, 8'hff);
    random_traffic(PHASE_BYTES);
    send_all();

    // Random phases under the remaining limits
    for (int p = 1; p < 5; p++) begin
      drain();
      write_limit(limits[p]);
      phase_no = p;
      random_traffic(PHASE_BYTES);
      send_all();
    end

    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/msfp_pkg.sv
src/motor_status_frame_parser.sv
dv/msfp_frame_checker.sv
dv/tb_motor_status_frame_parser.sv
